// ----- rtl/core/mrfc_pkg.sv -----
// Shared types, constants and the CRC byte update for the Modbus response frame checker.
package mrfc_pkg;

  // Byte count limit per frame, echo included.
  localparam int MAX_FRAME = 256;

  // Width of the byte counter and of the reported frame length.
  localparam int CNT_W = 9;

  // Depths of the command queue and of the result queue.
  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  // Fewest frame bytes a valid response can have.
  localparam logic [CNT_W-1:0] MIN_FRAME = CNT_W'(5);

  // CRC seed and reflected polynomial.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Configuration register indexes.
  localparam logic [1:0] CFG_EXP_ADDRESS  = 2'd0;
  localparam logic [1:0] CFG_EXP_FUNCTION = 2'd1;
  localparam logic [1:0] CFG_ECHO_LENGTH  = 2'd2;

  // Input item kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_EOF  = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_NO_RESPONSE    = 3'd1,
    ST_TOO_SHORT      = 3'd2,
    ST_WRONG_ADDRESS  = 3'd3,
    ST_EXCEPTION      = 3'd4,
    ST_WRONG_FUNCTION = 3'd5,
    ST_CRC_MISMATCH   = 3'd6
  } status_t;

  // Commands passed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_ADDRESS,   // first frame byte
    OP_FUNCTION,  // second frame byte
    OP_THIRD,     // third frame byte, also starts CRC feeding
    OP_DATA,      // any later frame byte
    OP_EOF        // end of frame, carries length and no-response flag
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       data;
    logic [CNT_W-1:0] len;
    logic             no_resp;
  } cmd_t;

  typedef struct packed {
    status_t          status;
    logic [CNT_W-1:0] len;
    logic [7:0]       exc;
  } result_t;

  // Byte-wide Modbus CRC-16 update, eight unrolled shift steps.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/mrfc_fifo.sv -----
// Small first-in first-out queue used between the front end, back end and result port.
module mrfc_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Pointer and occupancy update with explicit wrap.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset; occupancy says what is valid.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- rtl/core/mrfc_front.sv -----
// Front end: counts received bytes, drops echo and overflow bytes, classifies the rest.
module mrfc_front #(
  parameter int MAX_FRAME = mrfc_pkg::MAX_FRAME
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  input  logic                     in_kind,
  input  logic [7:0]               in_rx_byte,
  input  logic                     q_full,
  input  logic [7:0]               echo_length,
  output logic                     q_push,
  output mrfc_pkg::cmd_t           q_cmd
);

  logic [mrfc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [mrfc_pkg::CNT_W-1:0] echo_ext;
  logic [mrfc_pkg::CNT_W-1:0] k;
  logic                       accept;
  logic                       room;
  logic                       past_echo;

  assign accept    = in_push && !q_full;
  assign echo_ext  = {1'b0, echo_length};
  assign room      = (cnt_r < mrfc_pkg::CNT_W'(MAX_FRAME));
  assign past_echo = (cnt_r >= echo_ext);
  assign k         = cnt_r - echo_ext;

  // Classify the item and decide whether the back end needs to see it.
  always_comb begin
    q_cmd.op      = mrfc_pkg::OP_DATA;
    q_cmd.data    = in_rx_byte;
    q_cmd.len     = '0;
    q_cmd.no_resp = 1'b0;
    q_push        = 1'b0;
    cnt_nxt       = cnt_r;
    if (accept) begin
      if (in_kind == mrfc_pkg::KIND_EOF) begin
        q_cmd.op      = mrfc_pkg::OP_EOF;
        q_cmd.no_resp = !(cnt_r > echo_ext);
        q_cmd.len     = (cnt_r > echo_ext) ? k : '0;
        q_push        = 1'b1;
        cnt_nxt       = '0;
      end else if (room) begin
        cnt_nxt = cnt_r + 1'b1;
        if (past_echo) begin
          q_push = 1'b1;
          if (k == mrfc_pkg::CNT_W'(0)) begin
            q_cmd.op = mrfc_pkg::OP_ADDRESS;
          end else if (k == mrfc_pkg::CNT_W'(1)) begin
            q_cmd.op = mrfc_pkg::OP_FUNCTION;
          end else if (k == mrfc_pkg::CNT_W'(2)) begin
            q_cmd.op = mrfc_pkg::OP_THIRD;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/mrfc_back.sv -----
// Back end: runs the CRC, tracks header bytes and forms the end-of-frame verdict.
module mrfc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  mrfc_pkg::cmd_t    q_cmd,
  output logic              q_pop,
  input  logic [7:0]        exp_address,
  input  logic [6:0]        exp_function,
  input  logic              res_full,
  output logic              res_push,
  output mrfc_pkg::result_t res_data
);

  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  held0_r, held0_nxt;
  logic [7:0]  held1_r, held1_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [7:0]  func_r, func_nxt;
  logic [7:0]  third_r, third_nxt;
  logic        is_eof;

  assign is_eof   = (q_cmd.op == mrfc_pkg::OP_EOF);
  assign q_pop    = !q_empty && (!is_eof || !res_full);
  assign res_push = q_pop && is_eof;

  // Verdict in priority order.
  always_comb begin
    res_data.len = q_cmd.len;
    res_data.exc = '0;
    if (q_cmd.no_resp) begin
      res_data.status = mrfc_pkg::ST_NO_RESPONSE;
    end else if (q_cmd.len < mrfc_pkg::MIN_FRAME) begin
      res_data.status = mrfc_pkg::ST_TOO_SHORT;
    end else if (addr_r != exp_address) begin
      res_data.status = mrfc_pkg::ST_WRONG_ADDRESS;
    end else if (func_r == {1'b1, exp_function}) begin
      res_data.status = mrfc_pkg::ST_EXCEPTION;
      res_data.exc    = third_r;
    end else if (func_r != {1'b0, exp_function}) begin
      res_data.status = mrfc_pkg::ST_WRONG_FUNCTION;
    end else if ({held1_r, held0_r} != crc_r) begin
      res_data.status = mrfc_pkg::ST_CRC_MISMATCH;
    end else begin
      res_data.status = mrfc_pkg::ST_OK;
    end
  end

  // Frame state update per command.
  always_comb begin
    crc_nxt   = crc_r;
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    addr_nxt  = addr_r;
    func_nxt  = func_r;
    third_nxt = third_r;
    if (q_pop) begin
      if (is_eof) begin
        crc_nxt   = mrfc_pkg::CRC_INIT;
        held0_nxt = '0;
        held1_nxt = '0;
        addr_nxt  = '0;
        func_nxt  = '0;
        third_nxt = '0;
      end else begin
        held0_nxt = held1_r;
        held1_nxt = q_cmd.data;
        case (q_cmd.op)
          mrfc_pkg::OP_ADDRESS:  addr_nxt = q_cmd.data;
          mrfc_pkg::OP_FUNCTION: func_nxt = q_cmd.data;
          mrfc_pkg::OP_THIRD: begin
            third_nxt = q_cmd.data;
            crc_nxt   = mrfc_pkg::crc_feed(crc_r, held0_r);
          end
          default: crc_nxt = mrfc_pkg::crc_feed(crc_r, held0_r);
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= mrfc_pkg::CRC_INIT;
      held0_r <= '0;
      held1_r <= '0;
      addr_r  <= '0;
      func_r  <= '0;
      third_r <= '0;
    end else begin
      crc_r   <= crc_nxt;
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
      addr_r  <= addr_nxt;
      func_r  <= func_nxt;
      third_r <= third_nxt;
    end
  end

endmodule

// ----- rtl/core/modbus_response_frame_checker_core.sv -----
// Top level of the Modbus RTU response frame checker: config registers, queues, front and back.
// One item (a received byte or an end-of-frame marker) is taken per clock while in_full is
// low; the front end classifies it and the back end updates a byte-wide CRC. An end-of-frame
// marker passes through the two-entry command queue to the back end, which writes its result
// into the two-entry result queue when that queue has room; a full result queue backs up
// into the command queue and then raises in_full. Bytes past echo_length are checked, the
// first MAX_FRAME bytes of a frame (256 by default) count and later ones are dropped until
// the end-of-frame marker.
module modbus_response_frame_checker_core #(
  parameter int MAX_FRAME = mrfc_pkg::MAX_FRAME,
  parameter int CMD_DEPTH = mrfc_pkg::CMD_DEPTH,
  parameter int RES_DEPTH = mrfc_pkg::RES_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic                       in_kind,
  input  logic [7:0]                 in_rx_byte,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [2:0]                 out_status,
  output logic [mrfc_pkg::CNT_W-1:0] out_frame_length,
  output logic [7:0]                 out_exception_code,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [7:0]                 cfg_wdata
);

  logic [7:0] exp_address_r;
  logic [6:0] exp_function_r;
  logic [7:0] echo_length_r;

  logic              cmd_push, cmd_full, cmd_pop, cmd_empty;
  mrfc_pkg::cmd_t    cmd_in, cmd_out;
  logic              res_push, res_full;
  mrfc_pkg::result_t res_in, res_out;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_address_r  <= 8'd1;
      exp_function_r <= 7'd3;
      echo_length_r  <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        mrfc_pkg::CFG_EXP_ADDRESS:  exp_address_r  <= cfg_wdata;
        mrfc_pkg::CFG_EXP_FUNCTION: exp_function_r <= cfg_wdata[6:0];
        mrfc_pkg::CFG_ECHO_LENGTH:  echo_length_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_full = cmd_full;

  mrfc_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_kind     (in_kind),
    .in_rx_byte  (in_rx_byte),
    .q_full      (cmd_full),
    .echo_length (echo_length_r),
    .q_push      (cmd_push),
    .q_cmd       (cmd_in)
  );

  mrfc_fifo #(
    .W     ($bits(mrfc_pkg::cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  mrfc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (cmd_empty),
    .q_cmd        (cmd_out),
    .q_pop        (cmd_pop),
    .exp_address  (exp_address_r),
    .exp_function (exp_function_r),
    .res_full     (res_full),
    .res_push     (res_push),
    .res_data     (res_in)
  );

  mrfc_fifo #(
    .W     ($bits(mrfc_pkg::result_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_out),
    .empty (out_empty)
  );

  assign out_status         = res_out.status;
  assign out_frame_length   = res_out.len;
  assign out_exception_code = res_out.exc;

endmodule

// ----- rtl/core/mrfc_checker.sv -----
// Port-level checker for the frame checker core, with its bind statement.
module mrfc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_empty,
  input logic                       out_pop,
  input logic [2:0]                 out_status,
  input logic [mrfc_pkg::CNT_W-1:0] out_frame_length,
  input logic [7:0]                 out_exception_code
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // A no-response result always reports zero length.
  a_noresp_len: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == mrfc_pkg::ST_NO_RESPONSE) |-> out_frame_length == '0)
    else $error("no-response result with nonzero length");

  // Only an exception reply carries an exception code.
  a_exc_code: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != mrfc_pkg::ST_EXCEPTION) |-> out_exception_code == '0)
    else $error("exception code set on a non-exception result");

  // A too-short frame has between one and four bytes.
  a_short_len: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == mrfc_pkg::ST_TOO_SHORT)
      |-> (out_frame_length != '0 && out_frame_length < mrfc_pkg::MIN_FRAME))
    else $error("too-short result with impossible length");

  // A waiting result holds until its transfer.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_status)
      && $stable(out_frame_length)))
    else $error("waiting result changed before transfer");

endmodule

bind modbus_response_frame_checker_core mrfc_checker u_mrfc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_empty          (out_empty),
  .out_pop            (out_pop),
  .out_status         (out_status),
  .out_frame_length   (out_frame_length),
  .out_exception_code (out_exception_code)
);
